FILE: design/psd_pkg.sv
package psd_pkg;

    localparam int TableDepth = 16;
    localparam int ResultCap  = 16;
    localparam int AlertCntW  = $clog2(ResultCap + 1);

    localparam logic [15:0] CountMax = 16'hFFFF;

    // configuration defaults
    localparam logic [15:0] WarnThresholdRst = 16'd10;
    localparam logic [15:0] CheckIntervalRst = 16'd300;
    localparam logic [15:0] MaxAgeRst        = 16'd1000;
    localparam logic [15:0] LowPortLimitRst  = 16'd1024;

    // configuration register indexes
    localparam logic [1:0] CFG_WARN_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_CHECK_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MAX_AGE        = 2'd2;
    localparam logic [1:0] CFG_LOW_PORT_LIMIT = 2'd3;

    // request types
    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_COUNTED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_ALERT   = 2'd2;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] total;
        logic [15:0] low;
        logic [31:0] created;
        logic [31:0] due;
    } slot_data_t;

    typedef struct packed {
        logic       valid;
        slot_data_t data;
    } entry_t;

    typedef struct packed {
        logic [15:0] warn_threshold;
        logic [15:0] check_interval;
        logic [15:0] max_age;
        logic [15:0] low_port_limit;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic [31:0] addr;
        logic [15:0] port;
        logic        hit_any;
        logic        inserted;
        logic        cap_full;
        logic        head_match;
        logic [31:0] now;
    } head_ctl_t;

    typedef struct packed {
        logic alert;
        logic insert;
    } head_stat_t;

endpackage

FILE: design/psd_cell.sv
module psd_cell
    import psd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  entry_t      ent_in,
    input  logic [31:0] cmp_addr,
    output entry_t      ent_out,
    output logic        match
);

    logic       valid_reg;
    slot_data_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= ent_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= ent_in.data;
        end
    end

    assign ent_out.valid = valid_reg;
    assign ent_out.data  = data_reg;
    assign match         = valid_reg && (data_reg.addr == cmp_addr);

endmodule

FILE: design/psd_head.sv
module psd_head
    import psd_pkg::*;
(
    input  entry_t     ent_in,
    input  head_ctl_t  ctl,
    input  cfg_t       cfg,
    output entry_t     ent_out,
    output head_stat_t stat
);

    logic [31:0] since_due;
    logic [31:0] age;
    logic [31:0] next_due;
    logic        is_due;
    logic        port_low;
    logic [15:0] total_inc;
    logic [15:0] low_inc;

    assign since_due = ctl.now - ent_in.data.due;
    assign age       = ctl.now - ent_in.data.created;
    assign next_due  = ctl.now + {16'b0, cfg.check_interval};
    assign is_due    = !since_due[31];
    assign port_low  = ctl.port < cfg.low_port_limit;
    assign total_inc = (ent_in.data.total == CountMax) ? ent_in.data.total
                                                       : ent_in.data.total + 16'd1;
    assign low_inc   = (port_low && ent_in.data.low != CountMax) ? ent_in.data.low + 16'd1
                                                                 : ent_in.data.low;

    always_comb begin
        ent_out     = ent_in;
        stat.alert  = 1'b0;
        stat.insert = 1'b0;
        if (ctl.is_tick) begin
            if (ent_in.valid && is_due) begin
                if (ent_in.data.total > cfg.warn_threshold) begin
                    // over the alert cap the entry stays due for a later tick
                    if (!ctl.cap_full) begin
                        stat.alert    = 1'b1;
                        ent_out.valid = 1'b0;
                    end
                end else if (age > {16'b0, cfg.max_age}) begin
                    ent_out.valid = 1'b0;
                end else begin
                    ent_out.data.due = next_due;
                end
            end
        end else if (ctl.hit_any) begin
            if (ctl.head_match) begin
                ent_out.data.total = total_inc;
                ent_out.data.low   = low_inc;
            end
        end else if (!ctl.inserted && !ent_in.valid) begin
            stat.insert          = 1'b1;
            ent_out.valid        = 1'b1;
            ent_out.data.addr    = ctl.addr;
            ent_out.data.total   = 16'd1;
            ent_out.data.low     = port_low ? 16'd1 : 16'd0;
            ent_out.data.created = ctl.now;
            ent_out.data.due     = next_due;
        end
    end

endmodule

FILE: design/port_scan_detector_table.sv
// channel | direction | handshake         | payload
// s_      | in        | s_valid / s_ready | s_req_type, s_src_addr, s_dst_port
// m_      | out       | m_valid / m_ready | m_result_kind, m_alert_addr, m_alert_total,
//         |           |                   | m_alert_low, m_last
// cfg_    | in        | cfg_we            | cfg_index, cfg_wdata
//
// an item passes through accept, a parallel address match over the cells, one full
// rotation of the cell ring past the head logic, and a finish step that issues the
// final beat when one is due
// m_ready low stalls the ring only when a second alert meets a held one
// synchronous active-low reset clears valid bits, time and control and loads the config defaults
module port_scan_detector_table
    import psd_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepth
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_src_addr,
    input  logic [15:0] s_dst_port,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_alert_addr,
    output logic [15:0] m_alert_total,
    output logic [15:0] m_alert_low,
    output logic        m_last,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cfg_t cfg_reg, cfg_next;

    logic [31:0]          now_reg, now_next;
    logic                 req_tick_reg, req_tick_next;
    logic [31:0]          req_addr_reg, req_addr_next;
    logic [15:0]          req_port_reg, req_port_next;
    logic [IdxW-1:0]      idx_reg, idx_next;
    logic [AlertCntW-1:0] alert_cnt_reg, alert_cnt_next;
    logic                 hit_any_reg, hit_any_next;
    logic                 inserted_reg, inserted_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [31:0] pend_addr_reg, pend_addr_next;
    logic [15:0] pend_total_reg, pend_total_next;
    logic [15:0] pend_low_reg, pend_low_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [15:0] out_total_reg, out_total_next;
    logic [15:0] out_low_reg, out_low_next;
    logic        out_last_reg, out_last_next;

    entry_t                 cell_in  [TABLE_DEPTH];
    entry_t                 cell_out [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;

    entry_t     head_out;
    head_ctl_t  head_ctl;
    head_stat_t head_stat;

    logic out_free;
    logic walk_go;

    // ring of cells: slot i sits in cell i between items, the head sees cell 0
    // and its result enters the tail, so a full turn visits slots in order
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == TABLE_DEPTH - 1) begin : g_tail
            assign cell_in[k] = head_out;
        end else begin : g_mid
            assign cell_in[k] = cell_out[k+1];
        end

        psd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (walk_go),
            .ent_in   (cell_in[k]),
            .cmp_addr (req_addr_reg),
            .ent_out  (cell_out[k]),
            .match    (match_vec[k])
        );
    end

    assign head_ctl.is_tick    = req_tick_reg;
    assign head_ctl.addr       = req_addr_reg;
    assign head_ctl.port       = req_port_reg;
    assign head_ctl.hit_any    = hit_any_reg;
    assign head_ctl.inserted   = inserted_reg;
    assign head_ctl.cap_full   = (alert_cnt_reg == AlertCntW'(ResultCap));
    assign head_ctl.head_match = match_vec[0];
    assign head_ctl.now        = now_reg;

    psd_head u_head (
        .ent_in  (cell_out[0]),
        .ctl     (head_ctl),
        .cfg     (cfg_reg),
        .ent_out (head_out),
        .stat    (head_stat)
    );

    assign out_free = !out_valid_reg || m_ready;
    // hold the ring when a new alert would overwrite a held one that cannot leave
    assign walk_go  = (state_reg == ST_WALK)
                   && !(head_stat.alert && pend_valid_reg && !out_free);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_WARN_THRESHOLD: cfg_next.warn_threshold = cfg_wdata;
                CFG_CHECK_INTERVAL: cfg_next.check_interval = cfg_wdata;
                CFG_MAX_AGE:        cfg_next.max_age        = cfg_wdata;
                CFG_LOW_PORT_LIMIT: cfg_next.low_port_limit = cfg_wdata;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        req_tick_next   = req_tick_reg;
        req_addr_next   = req_addr_reg;
        req_port_next   = req_port_reg;
        idx_next        = idx_reg;
        alert_cnt_next  = alert_cnt_reg;
        hit_any_next    = hit_any_reg;
        inserted_next   = inserted_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_total_next = pend_total_reg;
        pend_low_next   = pend_low_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_addr_next   = out_addr_reg;
        out_total_next  = out_total_reg;
        out_low_next    = out_low_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_tick_next   = s_req_type;
                    req_addr_next   = s_src_addr;
                    req_port_next   = s_dst_port;
                    idx_next        = '0;
                    alert_cnt_next  = '0;
                    inserted_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    if (s_req_type == REQ_TICK) begin
                        now_next = now_reg + 32'd1;
                    end
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                hit_any_next = |match_vec;
                state_next   = ST_WALK;
            end
            ST_WALK: begin
                if (walk_go) begin
                    idx_next = idx_reg + 1'b1;
                    if (head_stat.insert) begin
                        inserted_next = 1'b1;
                    end
                    if (head_stat.alert) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ALERT;
                            out_addr_next  = pend_addr_reg;
                            out_total_next = pend_total_reg;
                            out_low_next   = pend_low_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_addr_next  = cell_out[0].data.addr;
                        pend_total_next = cell_out[0].data.total;
                        pend_low_next   = cell_out[0].data.low;
                        alert_cnt_next  = alert_cnt_reg + 1'b1;
                    end
                    if (idx_reg == IdxW'(TABLE_DEPTH - 1)) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (req_tick_reg == REQ_TICK) begin
                    if (!pend_valid_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_ALERT;
                        out_addr_next   = pend_addr_reg;
                        out_total_next  = pend_total_reg;
                        out_low_next    = pend_low_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (hit_any_reg || inserted_reg) ? KIND_COUNTED : KIND_FULL;
                    out_addr_next  = 32'd0;
                    out_total_next = 16'd0;
                    out_low_next   = 16'd0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= 32'd0;
            cfg_reg        <= '{warn_threshold: WarnThresholdRst,
                                check_interval: CheckIntervalRst,
                                max_age:        MaxAgeRst,
                                low_port_limit: LowPortLimitRst};
            idx_reg        <= '0;
            alert_cnt_reg  <= '0;
            hit_any_reg    <= 1'b0;
            inserted_reg   <= 1'b0;
            req_tick_reg   <= REQ_PROBE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            cfg_reg        <= cfg_next;
            idx_reg        <= idx_next;
            alert_cnt_reg  <= alert_cnt_next;
            hit_any_reg    <= hit_any_next;
            inserted_reg   <= inserted_next;
            req_tick_reg   <= req_tick_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_addr_reg   <= req_addr_next;
        req_port_reg   <= req_port_next;
        pend_addr_reg  <= pend_addr_next;
        pend_total_reg <= pend_total_next;
        pend_low_reg   <= pend_low_next;
        out_kind_reg   <= out_kind_next;
        out_addr_reg   <= out_addr_next;
        out_total_reg  <= out_total_next;
        out_low_reg    <= out_low_next;
        out_last_reg   <= out_last_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_alert_addr  = out_addr_reg;
    assign m_alert_total = out_total_reg;
    assign m_alert_low   = out_low_reg;
    assign m_last        = out_last_reg;

endmodule

FILE: dv/scan_table_checker.sv
module scan_table_checker
    import psd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_src_addr,
    input  logic [15:0] s_dst_port,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_result_kind,
    input  logic [31:0] m_alert_addr,
    input  logic [15:0] m_alert_total,
    input  logic [15:0] m_alert_low,
    input  logic        m_last,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    output int unsigned fail_count,
    output int unsigned pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] total;
        logic [15:0] low;
        logic        last;
    } result_beat_t;

    result_beat_t expected_beats[$];

    // shadow copy of the source table
    logic        tbl_valid   [TableDepth];
    logic [31:0] tbl_addr    [TableDepth];
    logic [15:0] tbl_total   [TableDepth];
    logic [15:0] tbl_low     [TableDepth];
    logic [31:0] tbl_created [TableDepth];
    logic [31:0] tbl_due     [TableDepth];
    logic [31:0] now_ticks;
    cfg_t        cfg;

    int unsigned mismatches = 0;

    function automatic void push_beat(input logic [1:0] kind, input logic [31:0] addr,
                                      input logic [15:0] total, input logic [15:0] low,
                                      input logic last);
        result_beat_t beat;
        beat.kind  = kind;
        beat.addr  = addr;
        beat.total = total;
        beat.low   = low;
        beat.last  = last;
        expected_beats.push_back(beat);
    endfunction

    function automatic void count_probe(input logic [31:0] addr, input logic [15:0] port);
        int slot;
        slot = -1;
        for (int i = 0; i < TableDepth; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_addr[i] == addr) slot = i;
        end
        if (slot < 0) begin
            for (int i = 0; i < TableDepth; i++) begin
                if (slot < 0 && !tbl_valid[i]) slot = i;
            end
            if (slot < 0) begin
                push_beat(KIND_FULL, '0, '0, '0, 1'b1);
                return;
            end
            tbl_valid[slot]   = 1'b1;
            tbl_addr[slot]    = addr;
            tbl_total[slot]   = '0;
            tbl_low[slot]     = '0;
            tbl_created[slot] = now_ticks;
            tbl_due[slot]     = now_ticks + cfg.check_interval;
        end
        if (tbl_total[slot] != CountMax) tbl_total[slot]++;
        if (port < cfg.low_port_limit && tbl_low[slot] != CountMax) tbl_low[slot]++;
        push_beat(KIND_COUNTED, '0, '0, '0, 1'b1);
    endfunction

    function automatic void check_due_entries();
        int           alerts;
        logic [31:0]  since_due;
        logic [31:0]  age;
        result_beat_t tail;
        alerts = 0;
        now_ticks++;
        for (int i = 0; i < TableDepth; i++) begin
            if (!tbl_valid[i]) continue;
            since_due = now_ticks - tbl_due[i];
            // due time still ahead, modulo wrap
            if (since_due[31]) continue;
            age = now_ticks - tbl_created[i];
            if (tbl_total[i] > cfg.warn_threshold) begin
                if (alerts >= ResultCap) continue;
                push_beat(KIND_ALERT, tbl_addr[i], tbl_total[i], tbl_low[i], 1'b0);
                alerts++;
                tbl_valid[i] = 1'b0;
            end else if (age > {16'd0, cfg.max_age}) begin
                tbl_valid[i] = 1'b0;
            end else begin
                tbl_due[i] = now_ticks + cfg.check_interval;
            end
        end
        if (alerts > 0) begin
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endfunction

    function automatic void note_failure(input string what, input result_beat_t want,
                                         input result_beat_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%t %s: expected kind %0d addr %h total %0d low %0d last %0d, ",
                   $realtime, what, want.kind, want.addr, want.total, want.low, want.last);
            $display("got kind %0d addr %h total %0d low %0d last %0d",
                     got.kind, got.addr, got.total, got.low, got.last);
        end
    endfunction

    always @(posedge aclk) begin
        result_beat_t got;
        result_beat_t want;
        if (!aresetn) begin
            cfg.warn_threshold = WarnThresholdRst;
            cfg.check_interval = CheckIntervalRst;
            cfg.max_age        = MaxAgeRst;
            cfg.low_port_limit = LowPortLimitRst;
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            now_ticks = '0;
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WARN_THRESHOLD: cfg.warn_threshold = cfg_wdata;
                    CFG_CHECK_INTERVAL: cfg.check_interval = cfg_wdata;
                    CFG_MAX_AGE:        cfg.max_age        = cfg_wdata;
                    CFG_LOW_PORT_LIMIT: cfg.low_port_limit = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_PROBE) count_probe(s_src_addr, s_dst_port);
                else check_due_entries();
            end
            if (m_valid && m_ready) begin
                got.kind  = m_result_kind;
                got.addr  = m_alert_addr;
                got.total = m_alert_total;
                got.low   = m_alert_low;
                got.last  = m_last;
                if (expected_beats.size() == 0) begin
                    want = '{default: '0};
                    note_failure("result beat with nothing pending", want, got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind !== want.kind || got.addr !== want.addr ||
                        got.total !== want.total || got.low !== want.low ||
                        got.last !== want.last)
                        note_failure("result beat mismatch", want, got);
                end
            end
        end
        pending_results <= expected_beats.size();
        fail_count      <= mismatches;
    end

endmodule

FILE: dv/port_scan_detector_table_tb.sv
module port_scan_detector_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psd_pkg::*;

    localparam int ItemCycles   = TableDepth + 3;
    localparam int SettleCycles = 3 * ItemCycles;
    localparam int StallLimit   = 3000;
    localparam int PoolSize     = 20;
    localparam int PhaseItems   = 43;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_req_type = REQ_PROBE;
    logic [31:0] s_src_addr = '0;
    logic [15:0] s_dst_port = '0;
    logic        m_ready    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = CFG_WARN_THRESHOLD;
    logic [15:0] cfg_wdata  = '0;

    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_result_kind;
    logic [31:0] m_alert_addr;
    logic [15:0] m_alert_total;
    logic [15:0] m_alert_low;
    logic        m_last;

    int unsigned fail_count;
    int unsigned pending_results;

    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;
    logic [15:0] cur_low_limit  = LowPortLimitRst;
    logic [31:0] addr_pool [PoolSize];

    always #5 aclk = ~aclk;

    port_scan_detector_table i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_src_addr    (s_src_addr),
        .s_dst_port    (s_dst_port),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_alert_addr  (m_alert_addr),
        .m_alert_total (m_alert_total),
        .m_alert_low   (m_alert_low),
        .m_last        (m_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    scan_table_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_src_addr      (s_src_addr),
        .s_dst_port      (s_dst_port),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_alert_addr    (m_alert_addr),
        .m_alert_total   (m_alert_total),
        .m_alert_low     (m_alert_low),
        .m_last          (m_last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    // ends the run when neither channel moves a beat for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic req, input logic [31:0] addr, input logic [15:0] port);
        if ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_gap_pct) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_src_addr <= addr;
        s_dst_port <= port;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every result is back, then let the design settle back to idle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [15:0] warn, input logic [15:0] interval,
                               input logic [15:0] age, input logic [15:0] low_limit);
        write_reg(CFG_WARN_THRESHOLD, warn);
        write_reg(CFG_CHECK_INTERVAL, interval);
        write_reg(CFG_MAX_AGE, age);
        write_reg(CFG_LOW_PORT_LIMIT, low_limit);
        cfg_we <= 1'b0;
        cur_low_limit = low_limit;
    endtask

    task automatic run_random(input int count);
        int unsigned pick;
        logic [31:0] addr;
        logic [15:0] port;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: port = 16'($urandom_range(0, 65535));
                1: port = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                2: port = cur_low_limit - 16'd1 + 16'($urandom_range(0, 2));
                default: port = 16'($urandom_range(0, 1023));
            endcase
            if (pick < 35) begin
                send_item(REQ_TICK, $urandom, 16'($urandom_range(0, 65535)));
            end else if (pick < 92) begin
                // skewed toward the first few sources so counts climb past the threshold
                addr = addr_pool[$urandom_range(0, $urandom_range(0, PoolSize - 1))];
                send_item(REQ_PROBE, addr, port);
            end else begin
                send_item(REQ_PROBE, $urandom, port);
            end
        end
    endtask

    initial begin
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < PoolSize; i++) addr_pool[i] = $urandom;

        src_gap_pct    = 22;
        sink_stall_pct = 64;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration, field extremes, tick with junk fields
        send_item(REQ_PROBE, 32'h0000_0000, 16'h0000);
        send_item(REQ_PROBE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        wait_idle();

        // zero interval, fill the table, overflow, then alert and age-out
        load_config(16'd2, 16'd0, 16'd3, 16'hFFFF);
        for (int a = 1; a <= 14; a++) send_item(REQ_PROBE, a, 16'hFFFF - a[0]);
        send_item(REQ_PROBE, 32'h8000_0001, 16'h8000);
        send_item(REQ_PROBE, 32'd1, 16'h0000);
        send_item(REQ_PROBE, 32'd1, 16'hFFFF);
        repeat (4) send_item(REQ_TICK, $urandom, 16'($urandom_range(0, 65535)));

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            if (phase == 3) begin
                src_gap_pct    = 64;
                sink_stall_pct = 22;
            end else if (phase == 6) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            case (phase)
                0: load_config(16'd3, 16'd2, 16'd6, 16'd1024);
                1: load_config(16'd0, 16'd1, 16'd1, 16'd0);
                2: load_config(16'd5, 16'd3, 16'hFFFF, 16'hFFFF);
                4: load_config(16'hFFFF, 16'd1, 16'd2, 16'd500);
                6: load_config(16'd1, 16'd1, 16'd20, 16'($urandom_range(0, 65535)));
                // long interval last: entries never come due, so the table fills up
                7: load_config(16'd2, 16'hFFFF, 16'd5, 16'($urandom_range(0, 65535)));
                default: load_config(16'($urandom_range(0, 8)), 16'($urandom_range(1, 4)),
                                     16'($urandom_range(1, 12)),
                                     16'($urandom_range(0, 65535)));
            endcase
            run_random(PhaseItems);
        end

        wait_idle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
